@@ hw/rtl/ptl_pkg.sv @@
package ptl_pkg;

   // default number of glyphs in the width table
   localparam int GLYPH_COUNT_DEF = 128;

   // character codes with special handling
   localparam logic [7:0] CODE_NEWLINE  = 8'd10;
   localparam logic [7:0] CODE_TAB      = 8'd9;
   localparam logic [7:0] CODE_NO_ADV   = 8'd203;
   localparam logic [7:0] CODE_FIRST    = 8'd32;

   // request modes
   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_CHAR  = 2'd2;

   // register indexes (paddr bit 2)
   localparam logic REG_LINE_HEIGHT = 1'b0;
   localparam logic REG_TAB_WIDTH   = 1'b1;

   // register reset values
   localparam logic [7:0]  LINE_HEIGHT_RST = 8'd16;
   localparam logic [10:0] TAB_WIDTH_RST   = 11'd64;

   // layout sequencer states
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIV    = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   // one result item
   typedef struct packed {
      logic               draw;
      logic signed [15:0] draw_x;
      logic signed [15:0] draw_y;
      logic [6:0]         glyph_number;
      logic [10:0]        advance;
      logic [15:0]        measured_width;
      logic [15:0]        line_count;
   } result_type;

endpackage

@@ hw/rtl/ptl_if.sv @@
// request channel into the layout block
interface ptl_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [6:0]         glyph_slot;
   logic [7:0]         slot_width;
   logic signed [15:0] start_x;
   logic signed [15:0] start_y;
   logic               render_enable;
   logic [7:0]         char_code;

   modport source (output valid, mode, glyph_slot, slot_width, start_x, start_y,
                   render_enable, char_code, input ready);
   modport sink   (input valid, mode, glyph_slot, slot_width, start_x, start_y,
                   render_enable, char_code, output ready);
endinterface

// result channel out of the layout block
interface ptl_rsp_if;
   logic               valid;
   logic               ready;
   logic               draw;
   logic signed [15:0] draw_x;
   logic signed [15:0] draw_y;
   logic [6:0]         glyph_number;
   logic [10:0]        advance;
   logic [15:0]        measured_width;
   logic [15:0]        line_count;

   modport source (output valid, draw, draw_x, draw_y, glyph_number, advance,
                   measured_width, line_count, input ready);
   modport sink   (input valid, draw, draw_x, draw_y, glyph_number, advance,
                   measured_width, line_count, output ready);
endinterface

@@ hw/rtl/ptl_rem.sv @@
// Restoring remainder unit: 16-bit dividend by 11-bit divisor, one bit per cycle.
module ptl_rem (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [10:0] divisor,
   output logic        done,
   output logic [10:0] remainder
);
   logic [15:0] shift_ff, shift_in;
   logic [10:0] rem_ff, rem_in;
   logic [10:0] div_ff, div_in;
   logic [4:0]  count_ff, count_in;
   logic        done_ff, done_in;
   logic [11:0] trial;

   always_comb begin
      trial    = {rem_ff, shift_ff[15]};
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      count_in = count_ff;
      done_in  = done_ff;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
         count_in = 5'd16;
         done_in  = 1'b0;
      end else if (count_ff != 5'd0) begin
         // shift in one dividend bit, subtract when it fits
         if (trial >= {1'b0, div_ff}) begin
            rem_in = 11'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[10:0];
         end
         shift_in = {shift_ff[14:0], 1'b0};
         count_in = count_ff - 5'd1;
         if (count_ff == 5'd1) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule

@@ hw/rtl/proportional_text_layout.sv @@
// Proportional text layout engine.
// Requests arrive on req_bus (valid/ready). Mode 0 loads one glyph width into
// the width table, mode 1 starts a string (origin, render flag, clears pen x
// and widest line, sets the line count to one), mode 2 lays out one character
// and yields one result on rsp_bus. Load and start requests yield nothing.
// A character reads the width table at the accepting edge and goes to the commit
// state, which writes the result register. A tab first goes to the divide state
// for 16 bit-serial remainder steps of pen_x mod tab_width, and to the commit
// state once the remainder is done.
// One request is in flight at a time; ready is high while the sequencer is
// idle, also while a finished result waits in the output register. When the
// receiver stalls, the next character completes its work and holds in the
// commit state until the output register is free.
// Reset clears the pen state, sets the line count to one and the registers
// to line_height 16 and tab_width 64. The width table is not cleared: an
// entry must be loaded before a character uses it.
// Registers on the csr_ APB port: line_height at 0x0, tab_width at 0x4.
module proportional_text_layout #(
   parameter int GLYPH_COUNT = ptl_pkg::GLYPH_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ptl_req_if.sink     req_bus,
   ptl_rsp_if.source   rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ptl_pkg::*;

   localparam int AW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
   localparam logic [8:0] GLYPH_LIMIT = 9'(GLYPH_COUNT);

   // width table
   logic [7:0] width_mem [GLYPH_COUNT];
   logic [7:0] rd_data_ff;

   // configuration registers
   logic [7:0]  line_height_ff, line_height_in;
   logic [10:0] tab_width_ff, tab_width_in;

   // layout state
   state_type          state_ff, state_in;
   logic [15:0]        pen_x_ff, pen_x_in;
   logic signed [15:0] pen_y_ff, pen_y_in;
   logic signed [15:0] origin_x_ff, origin_x_in;
   logic [15:0]        widest_ff, widest_in;
   logic [15:0]        lines_ff, lines_in;
   logic               render_ff, render_in;
   logic [7:0]         code_ff, code_in;
   logic               glyph_ok_ff, glyph_ok_in;
   result_type         out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   // request decode
   logic       accept;
   logic [7:0] req_idx;
   logic [7:0] load_slot;
   logic       load_we;

   // remainder unit
   logic        rem_start;
   logic        rem_done;
   logic [10:0] rem_value;
   logic [10:0] tab_eff;

   // commit datapath
   logic        commit;
   logic [7:0]  idx;
   logic [10:0] adv_raw;
   logic [16:0] pen_sum;
   logic [15:0] pen_next;
   logic [15:0] adv_moved;
   logic [17:0] dx_sum;
   logic [15:0] dx_sat;
   logic [16:0] dy_sum;
   logic [15:0] dy_sat;
   logic [15:0] widest_nl;

   assign accept    = req_bus.valid && req_bus.ready;
   assign req_idx   = 8'(req_bus.char_code - CODE_FIRST);
   assign load_slot = {1'b0, req_bus.glyph_slot};
   assign load_we   = accept && (req_bus.mode == MODE_LOAD)
                      && ({1'b0, load_slot} < GLYPH_LIMIT);
   assign tab_eff   = (tab_width_ff == 11'd0) ? 11'd1 : tab_width_ff;
   assign rem_start = accept && (req_bus.mode == MODE_CHAR)
                      && (req_bus.char_code == CODE_TAB);

   ptl_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (pen_x_ff),
      .divisor   (tab_eff),
      .done      (rem_done),
      .remainder (rem_value)
   );

   // width table: write on load, registered read on character acceptance
   always_ff @(posedge clock) begin
      if (load_we) begin
         width_mem[load_slot[AW-1:0]] <= req_bus.slot_width;
      end
      if (accept && (req_bus.mode == MODE_CHAR)) begin
         rd_data_ff <= width_mem[req_idx[AW-1:0]];
      end
   end

   // configuration writes
   always_comb begin
      line_height_in = line_height_ff;
      tab_width_in   = tab_width_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[2])
            REG_LINE_HEIGHT: line_height_in = csr_pwdata[7:0];
            REG_TAB_WIDTH:   tab_width_in   = csr_pwdata[10:0];
            default:         ;
         endcase
      end
   end

   // configuration reads
   always_comb begin
      case (csr_paddr[2])
         REG_LINE_HEIGHT: csr_prdata = {24'd0, line_height_ff};
         REG_TAB_WIDTH:   csr_prdata = {21'd0, tab_width_ff};
         default:         csr_prdata = '0;
      endcase
   end
   assign csr_pready = 1'b1;

   // commit arithmetic
   always_comb begin
      idx = 8'(code_ff - CODE_FIRST);
      if (code_ff == CODE_TAB) begin
         adv_raw = 11'(tab_eff - rem_value);
      end else if (glyph_ok_ff && (code_ff != CODE_NO_ADV)) begin
         adv_raw = {3'd0, rd_data_ff};
      end else begin
         adv_raw = '0;
      end
      // pen advance saturates at 65535
      pen_sum   = {1'b0, pen_x_ff} + {6'd0, adv_raw};
      pen_next  = pen_sum[16] ? 16'hFFFF : pen_sum[15:0];
      adv_moved = pen_next - pen_x_ff;
      // draw x from pen before the move, saturated upward
      dx_sum = {{2{origin_x_ff[15]}}, origin_x_ff} + {2'b00, pen_x_ff};
      if (!dx_sum[17] && (dx_sum[16:15] != 2'b00)) begin
         dx_sat = 16'h7FFF;
      end else begin
         dx_sat = dx_sum[15:0];
      end
      // next line top, saturated upward
      dy_sum = {pen_y_ff[15], pen_y_ff} + {9'd0, line_height_ff};
      dy_sat = (dy_sum[16] != dy_sum[15]) ? 16'h7FFF : dy_sum[15:0];
      widest_nl = (pen_x_ff > widest_ff) ? pen_x_ff : widest_ff;
   end

   assign commit = (state_ff == ST_COMMIT) && (!out_valid_ff || rsp_bus.ready);

   // sequencer and layout state update
   always_comb begin
      state_in     = state_ff;
      pen_x_in     = pen_x_ff;
      pen_y_in     = pen_y_ff;
      origin_x_in  = origin_x_ff;
      widest_in    = widest_ff;
      lines_in     = lines_ff;
      render_in    = render_ff;
      code_in      = code_ff;
      glyph_ok_in  = glyph_ok_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;

      if (out_valid_ff && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_bus.mode)
                  MODE_START: begin
                     origin_x_in = req_bus.start_x;
                     pen_y_in    = req_bus.start_y;
                     render_in   = req_bus.render_enable;
                     pen_x_in    = '0;
                     widest_in   = '0;
                     lines_in    = 16'd1;
                  end
                  MODE_CHAR: begin
                     code_in     = req_bus.char_code;
                     glyph_ok_in = ({1'b0, req_idx} < GLYPH_LIMIT);
                     state_in    = (req_bus.char_code == CODE_TAB) ? ST_DIV : ST_COMMIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            if (rem_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (commit) begin
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (code_ff == CODE_NEWLINE) begin
                  widest_in = widest_nl;
                  pen_x_in  = '0;
                  pen_y_in  = dy_sat;
                  if (lines_ff != 16'hFFFF) begin
                     lines_in = lines_ff + 16'd1;
                  end
                  out_in.draw           = 1'b0;
                  out_in.draw_x         = origin_x_ff;
                  out_in.draw_y         = dy_sat;
                  out_in.glyph_number   = '0;
                  out_in.advance        = '0;
                  out_in.measured_width = widest_nl;
                  out_in.line_count     = (lines_ff != 16'hFFFF) ? lines_ff + 16'd1
                                                                 : lines_ff;
               end else begin
                  pen_x_in = pen_next;
                  out_in.draw = (code_ff != CODE_TAB) && glyph_ok_ff && render_ff;
                  out_in.draw_x = dx_sat;
                  out_in.draw_y = pen_y_ff;
                  out_in.glyph_number = ((code_ff != CODE_TAB) && glyph_ok_ff)
                                        ? idx[6:0] : 7'd0;
                  out_in.advance        = adv_moved[10:0];
                  out_in.measured_width = (pen_next > widest_ff) ? pen_next : widest_ff;
                  out_in.line_count     = lines_ff;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         line_height_ff <= LINE_HEIGHT_RST;
         tab_width_ff   <= TAB_WIDTH_RST;
         pen_x_ff       <= '0;
         pen_y_ff       <= '0;
         origin_x_ff    <= '0;
         widest_ff      <= '0;
         lines_ff       <= 16'd1;
         render_ff      <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         line_height_ff <= line_height_in;
         tab_width_ff   <= tab_width_in;
         pen_x_ff       <= pen_x_in;
         pen_y_ff       <= pen_y_in;
         origin_x_ff    <= origin_x_in;
         widest_ff      <= widest_in;
         lines_ff       <= lines_in;
         render_ff      <= render_in;
         out_valid_ff   <= out_valid_in;
      end
      code_ff     <= code_in;
      glyph_ok_ff <= glyph_ok_in;
      out_ff      <= out_in;
   end

   // channel outputs
   assign req_bus.ready          = (state_ff == ST_IDLE);
   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.draw           = out_ff.draw;
   assign rsp_bus.draw_x         = out_ff.draw_x;
   assign rsp_bus.draw_y         = out_ff.draw_y;
   assign rsp_bus.glyph_number   = out_ff.glyph_number;
   assign rsp_bus.advance        = out_ff.advance;
   assign rsp_bus.measured_width = out_ff.measured_width;
   assign rsp_bus.line_count     = out_ff.line_count;
endmodule

@@ tb/tb_proportional_text_layout.sv @@
`timescale 1ns / 100ps

module tb_proportional_text_layout;
   import ptl_pkg::*;

   // mode 3 is not decoded by the block; used as noise
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   // idle cycles before a register write, covers the longest tab
   localparam int REG_SETTLE_CYCLES = 24;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_TAIL_CYCLES = 40;
   localparam int MAX_REPORTS = 10;

   typedef enum logic [1:0] {JOB_REQUEST, JOB_REGISTER, JOB_DRAIN} job_kind_type;

   // one entry of the stimulus queue: a request, a register write or a pause
   typedef struct {
      job_kind_type       kind;
      int                 gap;
      logic [1:0]         mode;
      logic [6:0]         glyph_slot;
      logic [7:0]         slot_width;
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
      logic               render_enable;
      logic [7:0]         char_code;
      logic               reg_index;
      logic [31:0]        reg_data;
   } layout_job_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ptl_req_if req_bus();
   ptl_rsp_if rsp_bus();

   proportional_text_layout dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // predicted layout state
   logic [7:0] glyph_width [GLYPH_COUNT_DEF];
   int         pen_x_now;
   int         pen_y_now;
   int         origin_x_now;
   int         widest_now;
   int         lines_now;
   logic       render_now;
   int         line_height_now;
   int         tab_width_now;
   result_type placements_due [$];

   // stimulus state
   layout_job_type layout_jobs [$];
   logic           slot_loaded [GLYPH_COUNT_DEF];
   int             loaded_slots [$];
   bit             sender_steady;
   int             sender_calm_left;

   // driver, monitor and watchdog state
   layout_job_type held_job;
   layout_job_type csr_job;
   bit         req_holding;
   int         csr_step;
   int         settle_count;
   int         stall_left;
   int         calm_left;
   bit         receiver_calm;
   int         mismatch_count;
   int         quiet_cycles;

   function automatic int clamp16(input int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // move the pen, saturating at 65535; returns the distance really moved
   function automatic int move_pen(input int amount);
      int target;
      target = pen_x_now + amount;
      if (target > 65535) target = 65535;
      amount = target - pen_x_now;
      pen_x_now = target;
      return amount;
   endfunction

   // predicted effect of one accepted request
   function automatic void place_request(input layout_job_type job);
      result_type res;
      int         slot;
      int         step;
      int         stop;
      case (job.mode)
         MODE_LOAD: glyph_width[job.glyph_slot] = job.slot_width;
         MODE_START: begin
            origin_x_now = job.start_x;
            pen_y_now = job.start_y;
            render_now = job.render_enable;
            pen_x_now = 0;
            widest_now = 0;
            lines_now = 1;
         end
         MODE_CHAR: begin
            res = '0;
            if (job.char_code == CODE_NEWLINE) begin
               if (pen_x_now > widest_now) widest_now = pen_x_now;
               pen_x_now = 0;
               pen_y_now = clamp16(pen_y_now + line_height_now);
               if (lines_now < 65535) lines_now++;
               res.draw_x = 16'(clamp16(origin_x_now + pen_x_now));
               res.draw_y = 16'(pen_y_now);
            end else if (job.char_code == CODE_TAB) begin
               // a zero tab width behaves as one
               stop = (tab_width_now == 0) ? 1 : tab_width_now;
               res.draw_x = 16'(clamp16(origin_x_now + pen_x_now));
               res.draw_y = 16'(pen_y_now);
               res.advance = 11'(move_pen(stop - pen_x_now % stop));
            end else begin
               slot = (int'(job.char_code) - int'(CODE_FIRST)) & 255;
               res.draw_x = 16'(clamp16(origin_x_now + pen_x_now));
               res.draw_y = 16'(pen_y_now);
               step = 0;
               if (slot < GLYPH_COUNT_DEF) begin
                  res.draw = render_now;
                  res.glyph_number = 7'(slot);
                  step = glyph_width[slot];
               end
               if (job.char_code != CODE_NO_ADV) res.advance = 11'(move_pen(step));
            end
            res.measured_width = 16'((pen_x_now > widest_now) ? pen_x_now : widest_now);
            res.line_count = 16'(lines_now);
            placements_due.push_back(res);
         end
         default: ;
      endcase
   endfunction

   function automatic void apply_register(input layout_job_type job);
      if (job.reg_index == REG_LINE_HEIGHT) line_height_now = job.reg_data[7:0];
      else tab_width_now = job.reg_data[10:0];
   endfunction

   function automatic string show_placement(input result_type r);
      return $sformatf("draw=%0d x=%0d y=%0d glyph=%0d adv=%0d width=%0d lines=%0d",
                       r.draw, r.draw_x, r.draw_y, r.glyph_number, r.advance,
                       r.measured_width, r.line_count);
   endfunction

   task automatic check_placement(input result_type got);
      result_type want;
      if (placements_due.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result with nothing expected: %s", $time, show_placement(got));
      end else begin
         want = placements_due.pop_front();
         if (want.draw !== got.draw || want.draw_x !== got.draw_x ||
             want.draw_y !== got.draw_y || want.glyph_number !== got.glyph_number ||
             want.advance !== got.advance || want.measured_width !== got.measured_width ||
             want.line_count !== got.line_count) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: expected %s, got %s", $time, show_placement(want),
                        show_placement(got));
         end
      end
   endtask

   // short idles mostly, a few long ones
   function automatic int idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int sender_gap();
      if (sender_steady) return 0;
      if (sender_calm_left > 0) begin
         sender_calm_left--;
         return 0;
      end
      if ($urandom_range(0, 29) == 0) begin
         sender_calm_left = $urandom_range(10, 60);
         return 0;
      end
      if ($urandom_range(0, 1) == 0) return 0;
      return idle_len();
   endfunction

   // request fields random, register fields zero; callers override what the mode uses
   function automatic layout_job_type random_job();
      layout_job_type job;
      job.kind = JOB_REQUEST;
      job.gap = sender_gap();
      job.mode = 2'($urandom);
      job.glyph_slot = 7'($urandom);
      job.slot_width = 8'($urandom);
      job.start_x = 16'($urandom);
      job.start_y = 16'($urandom);
      job.render_enable = 1'($urandom);
      job.char_code = 8'($urandom);
      job.reg_index = 1'b0;
      job.reg_data = '0;
      return job;
   endfunction

   task automatic add_load(input int slot, input int width);
      layout_job_type job;
      job = random_job();
      job.mode = MODE_LOAD;
      job.glyph_slot = 7'(slot);
      job.slot_width = 8'(width);
      layout_jobs.push_back(job);
      if (!slot_loaded[slot]) begin
         slot_loaded[slot] = 1'b1;
         loaded_slots.push_back(slot);
      end
   endtask

   task automatic add_start(input int sx, input int sy, input bit on);
      layout_job_type job;
      job = random_job();
      job.mode = MODE_START;
      job.start_x = 16'(sx);
      job.start_y = 16'(sy);
      job.render_enable = on;
      layout_jobs.push_back(job);
   endtask

   task automatic add_char(input logic [7:0] code);
      layout_job_type job;
      job = random_job();
      job.mode = MODE_CHAR;
      job.char_code = code;
      layout_jobs.push_back(job);
   endtask

   task automatic add_noise();
      layout_job_type job;
      job = random_job();
      job.mode = MODE_UNUSED;
      layout_jobs.push_back(job);
   endtask

   // unused upper data bits carry random junk
   task automatic add_register(input logic idx, input int value);
      layout_job_type job;
      job = random_job();
      job.kind = JOB_REGISTER;
      job.reg_index = idx;
      job.reg_data = $urandom;
      if (idx == REG_LINE_HEIGHT) job.reg_data[7:0] = value[7:0];
      else job.reg_data[10:0] = value[10:0];
      layout_jobs.push_back(job);
   endtask

   task automatic add_drain();
      layout_job_type job;
      job = random_job();
      job.kind = JOB_DRAIN;
      layout_jobs.push_back(job);
   endtask

   function automatic int random_width();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 0;
      if (roll == 1) return 255;
      return $urandom_range(0, 255);
   endfunction

   // only loaded slots are ever looked up
   function automatic logic [7:0] pick_char();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 62) return 8'(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)] + 32);
      if (roll < 72) return CODE_NEWLINE;
      if (roll < 82) return CODE_TAB;
      if (roll < 86) return CODE_NO_ADV;
      if (roll < 93) return 8'($urandom_range(0, 31));
      return 8'($urandom_range(160, 255));
   endfunction

   // request and register driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         csr_psel <= 1'b0;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b0;
         req_holding = 1'b0;
         csr_step = 0;
         settle_count = 0;
      end else begin
         // request taken: update the prediction
         if (req_bus.valid && req_bus.ready) begin
            place_request(held_job);
            req_holding = 1'b0;
         end
         // APB: setup, access, then done
         if (csr_step == 2) begin
            apply_register(csr_job);
            csr_psel <= 1'b0;
            csr_penable <= 1'b0;
            csr_pwrite <= 1'b0;
            csr_step = 0;
         end else if (csr_step == 1) begin
            csr_penable <= 1'b1;
            csr_step = 2;
         end else if (!req_holding && layout_jobs.size() != 0) begin
            case (layout_jobs[0].kind)
               JOB_REQUEST: begin
                  if (layout_jobs[0].gap > 0) begin
                     layout_jobs[0].gap = layout_jobs[0].gap - 1;
                  end else begin
                     held_job = layout_jobs.pop_front();
                     req_holding = 1'b1;
                     req_bus.mode <= held_job.mode;
                     req_bus.glyph_slot <= held_job.glyph_slot;
                     req_bus.slot_width <= held_job.slot_width;
                     req_bus.start_x <= held_job.start_x;
                     req_bus.start_y <= held_job.start_y;
                     req_bus.render_enable <= held_job.render_enable;
                     req_bus.char_code <= held_job.char_code;
                  end
               end
               JOB_REGISTER: begin
                  // block must be idle, including a tab that may still be running
                  if (placements_due.size() != 0) begin
                     settle_count = 0;
                  end else if (settle_count < REG_SETTLE_CYCLES) begin
                     settle_count++;
                  end else begin
                     csr_job = layout_jobs.pop_front();
                     settle_count = 0;
                     csr_psel <= 1'b1;
                     csr_pwrite <= 1'b1;
                     csr_paddr <= {csr_job.reg_index, 2'b00};
                     csr_pwdata <= csr_job.reg_data;
                     csr_step = 1;
                  end
               end
               default: begin
                  // hold off until every expected result is out
                  if (placements_due.size() == 0) void'(layout_jobs.pop_front());
               end
            endcase
         end
         req_bus.valid <= req_holding;
      end
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin : result_monitor
      result_type seen;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.draw = rsp_bus.draw;
            seen.draw_x = rsp_bus.draw_x;
            seen.draw_y = rsp_bus.draw_y;
            seen.glyph_number = rsp_bus.glyph_number;
            seen.advance = rsp_bus.advance;
            seen.measured_width = rsp_bus.measured_width;
            seen.line_count = rsp_bus.line_count;
            check_placement(seen);
         end
         // alternate stretches with and without stalls
         if (calm_left == 0) begin
            receiver_calm = ($urandom_range(0, 3) == 0);
            calm_left = $urandom_range(40, 400);
         end else begin
            calm_left--;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!receiver_calm && $urandom_range(0, 9) == 0) begin
            stall_left = idle_len() - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // no handshake of any kind for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int count;
      int len;
      int roll;
      int drain_point;
      bit drained;
      int lh;
      int tw;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_LOAD;
      req_bus.glyph_slot = '0;
      req_bus.slot_width = '0;
      req_bus.start_x = '0;
      req_bus.start_y = '0;
      req_bus.render_enable = 1'b0;
      req_bus.char_code = '0;
      rsp_bus.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;

      // predictor starts from the reset state
      for (int i = 0; i < GLYPH_COUNT_DEF; i++) begin
         glyph_width[i] = '0;
         slot_loaded[i] = 1'b0;
      end
      pen_x_now = 0;
      pen_y_now = 0;
      origin_x_now = 0;
      widest_now = 0;
      lines_now = 1;
      render_now = 1'b0;
      line_height_now = LINE_HEIGHT_RST;
      tab_width_now = TAB_WIDTH_RST;
      sender_steady = 1'b0;
      sender_calm_left = 0;
      mismatch_count = 0;
      stall_left = 0;
      calm_left = 0;

      // directed: width extremes, origin extremes, every code class
      add_load(0, 3);
      add_load(127, 255);
      add_load(33, 12);
      add_load(94, 0);
      add_load(1, 200);
      add_noise();
      add_start(-32768, 32767, 1'b1);
      add_char(8'd32);
      add_char(8'd65);
      add_char(8'd159);
      add_char(CODE_NO_ADV);
      add_char(8'd0);
      add_char(8'd255);
      add_char(CODE_TAB);
      add_char(CODE_NEWLINE);   // y saturates at the top
      add_char(8'd126);
      add_start(32767, -32768, 1'b0);
      add_char(8'd159);
      add_char(8'd33);          // draw_x saturates
      add_char(CODE_TAB);
      add_register(REG_TAB_WIDTH, 0);
      add_register(REG_LINE_HEIGHT, 0);
      add_char(CODE_TAB);
      add_char(CODE_NEWLINE);
      add_char(8'd33);
      add_register(REG_TAB_WIDTH, 2047);
      add_register(REG_LINE_HEIGHT, 255);
      add_char(CODE_TAB);
      add_char(CODE_NEWLINE);

      // random strings under several register settings
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin lh = 16;  tw = 64;   end
            1: begin lh = 255; tw = 2047; end
            2: begin lh = 0;   tw = 1;    end
            3: begin lh = 1;   tw = 0;    end
            default: begin
               lh = $urandom_range(0, 255);
               tw = $urandom_range(1, 2047);
            end
         endcase
         add_register(REG_LINE_HEIGHT, lh);
         add_register(REG_TAB_WIDTH, tw);
         if (phase == 0) repeat (48) add_load($urandom_range(0, 127), random_width());
         count = 0;
         drained = 1'b0;
         drain_point = $urandom_range(20, 80);
         while (count < 90) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               add_load($urandom_range(0, 127), random_width());
               count++;
            end else if (roll < 11) begin
               add_noise();
            end else begin
               len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 20) : $urandom_range(21, 60);
               // most strings open with a start, some just carry on
               if (roll < 20) begin
                  count += len;
               end else begin
                  add_start(16'($urandom), 16'($urandom), $urandom_range(0, 3) != 0);
                  count += len + 1;
               end
               repeat (len) add_char(pick_char());
            end
            if (!drained && count >= drain_point) begin
               add_drain();
               drained = 1'b1;
            end
         end
      end

      // pen saturation: partial glyph advance, then no movement at all
      add_register(REG_LINE_HEIGHT, 255);
      add_register(REG_TAB_WIDTH, 2047);
      add_load(127, 255);
      add_start(32767, 32000, 1'b1);
      repeat (32) add_char(CODE_TAB);
      add_char(8'd159);
      add_char(8'd159);
      add_char(CODE_TAB);
      add_char(CODE_NEWLINE);
      add_char(CODE_NEWLINE);
      add_char(8'd159);

      // back-to-back newlines
      add_register(REG_LINE_HEIGHT, 1);
      add_register(REG_TAB_WIDTH, TAB_WIDTH_RST);
      add_start(-5, -32768, 1'b1);
      sender_steady = 1'b1;
      repeat (40) add_char(CODE_NEWLINE);
      sender_steady = 1'b0;
      add_char(pick_char());
      add_char(CODE_TAB);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (layout_jobs.size() != 0 || req_holding || placements_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && placements_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/ptl_pkg.sv
hw/rtl/ptl_if.sv
hw/rtl/ptl_rem.sv
hw/rtl/proportional_text_layout.sv
tb/tb_proportional_text_layout.sv
